### src/halfband_mipmap_decimator_unit_macros.svh
// Assertion helpers for the half-band mipmap decimator.
// Each check is clocked on the rising edge and is held off while reset is asserted.
`ifndef HALFBAND_MIPMAP_DECIMATOR_UNIT_MACROS_SVH
`define HALFBAND_MIPMAP_DECIMATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define HMD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define HMD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HMD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define HMD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

### src/hmd_pkg.sv
`default_nettype none

package hmd_pkg;

	// Store and filter dimensions.
	localparam int MAX_LOG2_SIZE = 12;
	localparam int TAP_COUNT = 63;
	localparam int TAP_CENTER = 31;
	localparam int SUM_SHIFT = 16;
	localparam int SAMPLE_W = 16;
	localparam int INDEX_W = 12;
	localparam int CFG_W = 4;
	localparam int TAP_W = 6;
	// Largest sum is below 2^34 in magnitude, so 36 bits leave margin.
	localparam int ACC_W = 36;
	localparam logic [CFG_W-1:0] TABLE_LOG2_RESET = 4'd12;

	// Half-band filter weights; taps 1 to 62 are symmetric about the two center taps.
	localparam logic signed [SAMPLE_W-1:0] TAP_WEIGHT [TAP_COUNT] = '{
		16'sd1, 16'sd33, -16'sd8, -16'sd48, 16'sd31, 16'sd72, -16'sd74, -16'sd92,
		16'sd143, 16'sd95, -16'sd240, -16'sd66, 16'sd364, -16'sd14, -16'sd505,
		16'sd168, 16'sd642, -16'sd416, -16'sd748, 16'sd779, 16'sd782, -16'sd1279,
		-16'sd687, 16'sd1951, 16'sd375, -16'sd2874, 16'sd331, 16'sd4293,
		-16'sd1957, -16'sd7315, 16'sd7773, 16'sd31275, 16'sd31275, 16'sd7773,
		-16'sd7315, -16'sd1957, 16'sd4293, 16'sd331, -16'sd2874, 16'sd375,
		16'sd1951, -16'sd687, -16'sd1279, 16'sd782, 16'sd779, -16'sd748,
		-16'sd416, 16'sd642, 16'sd168, -16'sd505, -16'sd14, 16'sd364, -16'sd66,
		-16'sd240, 16'sd95, 16'sd143, -16'sd92, -16'sd74, 16'sd72, 16'sd31,
		-16'sd48, -16'sd8, 16'sd33
	};

	// Request function codes.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// Input request payload.
	typedef struct packed {
		logic func;
		logic [INDEX_W-1:0] index;
		logic signed [SAMPLE_W-1:0] sample;
	} in_req_t;

	// Output result payload.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic clipped;
	} out_rsp_t;

	// Microprogram steps.
	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_DECODE = 3'd1,
		ST_MAC = 3'd2,
		ST_DRAIN1 = 3'd3,
		ST_DRAIN2 = 3'd4,
		ST_RESULT = 3'd5,
		ST_WRITE = 3'd6
	} step_t;

	// Jump conditions of the microprogram.
	typedef enum logic [2:0] {
		COND_ALWAYS = 3'd0,
		COND_REQ = 3'd1,
		COND_WRITE = 3'd2,
		COND_TAPS_DONE = 3'd3,
		COND_OUT_FREE = 3'd4
	} cond_t;

	// Datapath strobes from the sequencer.
	typedef struct packed {
		logic take;
		logic setup;
		logic issue;
		logic mem_we;
		logic out_load;
	} ctl_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic req_valid;
		logic is_write;
		logic tap_last;
		logic out_free;
	} stat_t;

	// One microcode word: strobes, a condition and two successors.
	typedef struct packed {
		ctl_t ctl;
		cond_t cond;
		step_t jmp;
		step_t alt;
	} ucw_t;

endpackage

`default_nettype wire

### src/halfband_mipmap_decimator_unit.sv
`default_nettype none
`include "halfband_mipmap_decimator_unit_macros.svh"

// Half-band mipmap decimator. Write requests (func 0) store a sample in a table of
// 2^table_log2 entries; read requests (func 1) return one half-rate output sample, the
// 63-tap half-band sum around source position 2*index, shifted right by 16 and saturated
// to 16 bits with clipped set on saturation; a write returns a zero result. Requests are
// handled one at a time: a write steps through decode, store write and result, a read
// through setup, one multiply-accumulate step per tap, the pipeline drain and result,
// paced by the single-port sample store feeding one multiplier one tap per cycle. A
// stalled output holds the result step. The store is not cleared at reset; a read that
// touches an entry never written returns an unspecified value.
// table_log2 resets to 12 and should be written only while the block is idle.
module halfband_mipmap_decimator_unit #(
	parameter int MAX_LOG2_SIZE = hmd_pkg::MAX_LOG2_SIZE
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire hmd_pkg::in_req_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output hmd_pkg::out_rsp_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [hmd_pkg::CFG_W-1:0] cfg_data
);

	localparam int AW = MAX_LOG2_SIZE;
	localparam int LW = $clog2(MAX_LOG2_SIZE + 1);
	localparam int SH_W = hmd_pkg::ACC_W - hmd_pkg::SUM_SHIFT;
	localparam int SW = hmd_pkg::SAMPLE_W;

	hmd_pkg::ctl_t ctl;
	hmd_pkg::stat_t stat;
	hmd_pkg::in_req_t req_q;
	hmd_pkg::out_rsp_t rsp_q;

	logic [hmd_pkg::CFG_W-1:0] table_log2_q;
	logic [hmd_pkg::CFG_W:0] cfg_w;
	logic [LW-1:0] eff_log2;
	logic [AW:0] len_w;
	logic [AW:0] len_m1;
	logic [AW-1:0] mask;
	logic [AW+hmd_pkg::INDEX_W-1:0] idx_wide;
	logic [AW-1:0] idx_a;
	logic [AW-1:0] base;

	logic [AW-1:0] addr_q;
	logic [hmd_pkg::TAP_W-1:0] tap_q;
	logic [SW-1:0] mem [2**AW];
	logic signed [SW-1:0] rdata_s1;
	logic signed [SW-1:0] coef_s1;
	logic v_s1;
	logic signed [2*SW-1:0] prod_s2;
	logic v_s2;
	logic signed [hmd_pkg::ACC_W-1:0] acc_q;

	logic [SH_W-1:0] sh;
	logic clip;
	logic [SW-1:0] sat;
	logic out_valid_q;
	logic out_free;
	logic in_acc;
	logic load;

	// Configuration register; always ready.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_log2_q <= hmd_pkg::TABLE_LOG2_RESET;
		end else if (cfg_valid && cfg_ready) begin
			table_log2_q <= cfg_data;
		end
	end

	// Effective table size, clamped to 1..MAX_LOG2_SIZE, and its address mask.
	always_comb begin
		cfg_w = {1'b0, table_log2_q};
		if (cfg_w == '0) begin
			eff_log2 = LW'(1);
		end else if (cfg_w > (hmd_pkg::CFG_W + 1)'(MAX_LOG2_SIZE)) begin
			eff_log2 = LW'(MAX_LOG2_SIZE);
		end else begin
			eff_log2 = LW'(cfg_w);
		end
		len_w = (AW + 1)'(1) << eff_log2;
		len_m1 = len_w - (AW + 1)'(1);
		mask = len_m1[AW-1:0];
	end

	// Request index in store address width, and first tap position 2i - 31.
	always_comb begin
		idx_wide = {{AW{1'b0}}, req_q.index};
		idx_a = idx_wide[AW-1:0];
		base = ((idx_a << 1) - AW'(hmd_pkg::TAP_CENTER)) & mask;
	end

	// Request capture.
	assign in_stall = !ctl.take;
	assign in_acc = in_valid && !in_stall;
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= in_data;
		end
	end

	// Tap address and tap counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			tap_q <= '0;
		end else if (ctl.setup) begin
			addr_q <= base;
			tap_q <= '0;
		end else if (ctl.issue) begin
			addr_q <= (addr_q + AW'(1)) & mask;
			tap_q <= tap_q + hmd_pkg::TAP_W'(1);
		end
	end

	// Sample store: one write address, one registered read.
	always_ff @(posedge clk) begin
		if (ctl.mem_we) begin
			mem[idx_a & mask] <= req_q.sample;
		end
		if (ctl.issue) begin
			rdata_s1 <= mem[addr_q];
			coef_s1 <= hmd_pkg::TAP_WEIGHT[tap_q];
		end
	end

	// Multiply stage.
	always_ff @(posedge clk) begin
		prod_s2 <= rdata_s1 * coef_s1;
	end

	// Pipeline valid bits and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			if (ctl.setup) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + hmd_pkg::ACC_W'(prod_s2);
			end
		end
	end

	// Floor shift by 16 and saturation to 16 bits.
	always_comb begin
		sh = acc_q[hmd_pkg::ACC_W-1:hmd_pkg::SUM_SHIFT];
		clip = !((&sh[SH_W-1:SW-1]) || !(|sh[SH_W-1:SW-1]));
		if (!clip) begin
			sat = sh[SW-1:0];
		end else if (sh[SH_W-1]) begin
			sat = {1'b1, {(SW - 1){1'b0}}};
		end else begin
			sat = {1'b0, {(SW - 1){1'b1}}};
		end
	end

	// Output register.
	assign out_free = !out_valid_q || !out_stall;
	assign load = ctl.out_load && out_free;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (req_q.func == hmd_pkg::FUNC_READ) begin
				rsp_q.filtered <= sat;
				rsp_q.clipped <= clip;
			end else begin
				rsp_q.filtered <= '0;
				rsp_q.clipped <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = rsp_q;

	// Sequencer status.
	always_comb begin
		stat.req_valid = in_valid;
		stat.is_write = (req_q.func == hmd_pkg::FUNC_WRITE);
		stat.tap_last = (tap_q == hmd_pkg::TAP_W'(hmd_pkg::TAP_COUNT - 1));
		stat.out_free = out_free;
	end

	hmd_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.ctl(ctl)
	);

	// Checks on the sequencing of the datapath.
	`HMD_ASSERT_NXT(a_accept_setup, clk, arst_n, in_acc, ctl.setup, "accept not followed by setup")
	`HMD_ASSERT_IMP(a_write_only, clk, arst_n, ctl.mem_we, req_q.func == hmd_pkg::FUNC_WRITE, "store written on a read")
	`HMD_ASSERT_IMP(a_all_taps, clk, arst_n, load && (req_q.func == hmd_pkg::FUNC_READ), tap_q == hmd_pkg::TAP_W'(hmd_pkg::TAP_COUNT), "result before all taps")
	`HMD_ASSERT_IMP(a_drained, clk, arst_n, ctl.out_load, !v_s1 && !v_s2, "result while pipeline busy")
	`HMD_ASSERT_IMP(a_no_overwrite, clk, arst_n, load && out_valid_q, !out_stall, "pending result overwritten")

endmodule

`default_nettype wire

### src/hmd_seq.sv
`default_nettype none

module hmd_seq (
	input wire logic clk,
	input wire logic arst_n,
	input wire hmd_pkg::stat_t stat,
	output hmd_pkg::ctl_t ctl
);

	hmd_pkg::step_t step_q;
	hmd_pkg::step_t step_nxt;
	hmd_pkg::ucw_t word;
	logic cond_hit;

	// Microprogram ROM: one word per step.
	function automatic hmd_pkg::ucw_t ucode(input hmd_pkg::step_t s);
		hmd_pkg::ucw_t w;
		w = '{ctl: '0, cond: hmd_pkg::COND_ALWAYS, jmp: hmd_pkg::ST_IDLE,
			alt: hmd_pkg::ST_IDLE};
		case (s)
			hmd_pkg::ST_IDLE: begin
				w.ctl.take = 1'b1;
				w.cond = hmd_pkg::COND_REQ;
				w.jmp = hmd_pkg::ST_DECODE;
				w.alt = hmd_pkg::ST_IDLE;
			end
			hmd_pkg::ST_DECODE: begin
				w.ctl.setup = 1'b1;
				w.cond = hmd_pkg::COND_WRITE;
				w.jmp = hmd_pkg::ST_WRITE;
				w.alt = hmd_pkg::ST_MAC;
			end
			hmd_pkg::ST_MAC: begin
				w.ctl.issue = 1'b1;
				w.cond = hmd_pkg::COND_TAPS_DONE;
				w.jmp = hmd_pkg::ST_DRAIN1;
				w.alt = hmd_pkg::ST_MAC;
			end
			hmd_pkg::ST_DRAIN1: begin
				w.jmp = hmd_pkg::ST_DRAIN2;
			end
			hmd_pkg::ST_DRAIN2: begin
				w.jmp = hmd_pkg::ST_RESULT;
			end
			hmd_pkg::ST_RESULT: begin
				w.ctl.out_load = 1'b1;
				w.cond = hmd_pkg::COND_OUT_FREE;
				w.jmp = hmd_pkg::ST_IDLE;
				w.alt = hmd_pkg::ST_RESULT;
			end
			hmd_pkg::ST_WRITE: begin
				w.ctl.mem_we = 1'b1;
				w.jmp = hmd_pkg::ST_RESULT;
			end
			default: begin
				w.jmp = hmd_pkg::ST_IDLE;
			end
		endcase
		return w;
	endfunction

	// Output decode: the current step's word drives the datapath.
	always_comb begin
		word = ucode(step_q);
		ctl = word.ctl;
	end

	// Next step: evaluate the word's condition and pick a successor.
	always_comb begin
		case (word.cond)
			hmd_pkg::COND_ALWAYS: cond_hit = 1'b1;
			hmd_pkg::COND_REQ: cond_hit = stat.req_valid;
			hmd_pkg::COND_WRITE: cond_hit = stat.is_write;
			hmd_pkg::COND_TAPS_DONE: cond_hit = stat.tap_last;
			hmd_pkg::COND_OUT_FREE: cond_hit = stat.out_free;
			default: cond_hit = 1'b1;
		endcase
		step_nxt = cond_hit ? word.jmp : word.alt;
	end

	// Step register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= hmd_pkg::ST_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

`default_nettype wire
